>>> rtl/sbl_pkg.sv
// Shared types, constants and the abbreviation table of the sentence boundary locator.
package sbl_pkg;

    localparam int POS_W         = 16;
    localparam int MAX_TEXT_LEN  = 65535;
    localparam int WORD_TAIL_LEN = 7;
    localparam int WLEN_W        = 4;
    localparam int TAIL_W        = 8 * WORD_TAIL_LEN;
    localparam int NUM_ABBR      = 22;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_INDEX = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_FIRST = 1'd1;

    localparam logic [1:0] MODE_SKIP  = 2'd0;
    localparam logic [1:0] MODE_BODY  = 2'd1;
    localparam logic [1:0] MODE_TERM  = 2'd2;
    localparam logic [1:0] MODE_CLOSE = 2'd3;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_only;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [POS_W-1:0] sentence_start;
        logic [POS_W-1:0] sentence_end;
    } t_out;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        logic             take;
        logic             ws;
        logic             term;
        logic             closer;
        logic             brk;
        logic             last;
        logic [POS_W-1:0] len;
    } t_cls;

    // Entries are right-aligned: the final character sits in the low byte.
    localparam logic [TAIL_W-1:0] ABBR_TXT [NUM_ABBR] = '{
        TAIL_W'("e.g."), TAIL_W'("i.e."), TAIL_W'("etc."), TAIL_W'("mr."),
        TAIL_W'("mrs."), TAIL_W'("ms."), TAIL_W'("dr."), TAIL_W'("vs."),
        TAIL_W'("prof."), TAIL_W'("inc."), TAIL_W'("corp."), TAIL_W'("ltd."),
        TAIL_W'("al."), TAIL_W'("st."), TAIL_W'("approx."), TAIL_W'("dept."),
        TAIL_W'("fig."), TAIL_W'("figs."), TAIL_W'("no."), TAIL_W'("vol."),
        TAIL_W'("v."), TAIL_W'("gen.")
    };

    localparam logic [WLEN_W-1:0] ABBR_LEN [NUM_ABBR] = '{
        4'd4, 4'd4, 4'd4, 4'd3, 4'd4, 4'd3, 4'd3, 4'd3, 4'd5, 4'd4, 4'd5,
        4'd4, 4'd3, 4'd3, 4'd7, 4'd5, 4'd4, 4'd5, 4'd3, 4'd4, 4'd2, 4'd4
    };

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_term(input logic [7:0] b);
        return (b == 8'h2E) || (b == 8'h21) || (b == 8'h3F);
    endfunction

    function automatic logic is_closer(input logic [7:0] b);
        return (b == 8'h22) || (b == 8'h27) || (b == 8'h29) ||
               (b == 8'h5D) || (b == 8'h7D) || (b == 8'h3E);
    endfunction

    // Compares the whole current word against every abbreviation at once.
    function automatic logic is_abbrev(input logic [TAIL_W-1:0] tail,
                                       input logic [WLEN_W-1:0] wlen);
        logic              hit;
        logic [TAIL_W-1:0] mask;
        hit = 1'b0;
        for (int k = 0; k < NUM_ABBR; k++) begin
            mask = {TAIL_W{1'b1}} >> (8 * (WORD_TAIL_LEN - int'(ABBR_LEN[k])));
            if (wlen == ABBR_LEN[k] && (tail & mask) == (ABBR_TXT[k] & mask)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

>>> rtl/sbl_front.sv
// Front end: accepts text bytes, tracks position and the current word, classifies each byte.
module sbl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sbl_pkg::t_in  i_in_item,
    input  logic          i_q_full,
    output logic          o_q_push,
    output sbl_pkg::t_cls o_q_item
);
    import sbl_pkg::*;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [TAIL_W-1:0] r_tail, n_tail;
    logic [WLEN_W-1:0] r_wlen, n_wlen;

    logic       accept;
    logic       take;
    logic       ws;
    logic [7:0] low;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign take       = !i_in_item.end_only && (32'(r_pos) < MAX_TEXT_LEN);
    assign ws         = is_ws(i_in_item.char_byte);
    assign low        = (i_in_item.char_byte >= 8'h41 && i_in_item.char_byte <= 8'h5A) ?
                        (i_in_item.char_byte + 8'd32) : i_in_item.char_byte;

    always_comb begin
        n_pos  = r_pos;
        n_tail = r_tail;
        n_wlen = r_wlen;
        if (take) begin
            n_pos = r_pos + 1'b1;
            if (ws) begin
                n_wlen = '0;
            end else begin
                n_tail = {r_tail[TAIL_W-9:0], low};
                if (32'(r_wlen) <= WORD_TAIL_LEN) begin
                    n_wlen = r_wlen + 1'b1;
                end
            end
        end
    end

    // The abbreviation test sees the word with the current byte already in it.
    always_comb begin
        o_q_item.take   = take;
        o_q_item.ws     = ws;
        o_q_item.term   = is_term(i_in_item.char_byte);
        o_q_item.closer = is_closer(i_in_item.char_byte);
        o_q_item.brk    = is_term(i_in_item.char_byte) &&
                          !(i_in_item.char_byte == 8'h2E && is_abbrev(n_tail, n_wlen));
        o_q_item.last   = i_in_item.last;
        o_q_item.len    = n_pos;
    end

    assign o_q_push = accept && (take || i_in_item.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_tail <= '0;
            r_wlen <= '0;
        end else if (accept) begin
            if (i_in_item.last) begin
                r_pos  <= '0;
                r_tail <= '0;
                r_wlen <= '0;
            end else begin
                r_pos  <= n_pos;
                r_tail <= n_tail;
                r_wlen <= n_wlen;
            end
        end
    end

endmodule

>>> rtl/sbl_queue.sv
// Small register queue between the front end and the back end.
module sbl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sbl_pkg::t_cls i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sbl_pkg::t_cls o_data
);
    import sbl_pkg::*;

    t_cls               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr, r_rd;
    logic [QPTR_W:0]    r_count;

    logic do_push, do_pop;

    assign o_full  = (32'(r_count) == QUEUE_DEPTH);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/sbl_back.sv
// Back end: sentence scanner, target selection and the result register.
module sbl_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  sbl_pkg::t_cls                i_q_item,
    output logic                         o_q_pop,
    input  logic [sbl_pkg::POS_W-1:0]    i_target_index,
    input  logic                         i_select_first,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output sbl_pkg::t_out                o_out_item
);
    import sbl_pkg::*;

    logic [1:0]       r_mode, n_mode;
    logic [POS_W-1:0] r_cur_start, n_cur_start;
    logic [POS_W-1:0] r_lne, n_lne;
    logic [POS_W-1:0] r_ch_start, n_ch_start;
    logic [POS_W-1:0] r_ch_end, n_ch_end;
    logic             r_match, n_match;
    logic             r_any, n_any;
    logic             r_out_valid;
    t_out             r_out;

    logic pop;
    logic add_req;
    logic hit;

    assign pop     = i_q_valid && (!i_q_item.last || !r_out_valid || !i_out_stall);
    assign o_q_pop = pop;

    always_comb begin
        n_mode      = r_mode;
        n_cur_start = r_cur_start;
        n_lne       = r_lne;
        add_req     = 1'b0;
        if (i_q_item.take) begin
            if (!i_q_item.ws) begin
                n_lne = i_q_item.len;
            end
            case (r_mode)
                MODE_SKIP: begin
                    if (!i_q_item.ws) begin
                        n_cur_start = i_q_item.len - 1'b1;
                        n_mode      = i_q_item.brk ? MODE_TERM : MODE_BODY;
                    end
                end
                MODE_TERM: begin
                    if (i_q_item.ws) begin
                        add_req = 1'b1;
                        n_mode  = MODE_SKIP;
                    end else if (i_q_item.closer) begin
                        n_mode = MODE_CLOSE;
                    end else if (!i_q_item.term) begin
                        n_mode = MODE_BODY;
                    end
                end
                MODE_CLOSE: begin
                    if (i_q_item.ws) begin
                        add_req = 1'b1;
                        n_mode  = MODE_SKIP;
                    end else if (!i_q_item.closer) begin
                        n_mode = i_q_item.brk ? MODE_TERM : MODE_BODY;
                    end
                end
                default: begin
                    if (!i_q_item.ws && i_q_item.brk) begin
                        n_mode = MODE_TERM;
                    end
                end
            endcase
        end
        // The end of text closes an unfinished tail sentence.
        if (i_q_item.last && n_mode != MODE_SKIP) begin
            add_req = 1'b1;
        end
    end

    assign hit = (i_target_index >= n_cur_start) && (i_target_index <= n_lne);

    always_comb begin
        n_ch_start = r_ch_start;
        n_ch_end   = r_ch_end;
        n_match    = r_match;
        n_any      = r_any;
        if (add_req && (!r_any || (!i_select_first && !r_match))) begin
            n_ch_start = n_cur_start;
            n_ch_end   = n_lne;
            n_match    = hit;
            n_any      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SKIP;
            r_cur_start <= '0;
            r_lne       <= '0;
            r_ch_start  <= '0;
            r_ch_end    <= '0;
            r_match     <= 1'b0;
            r_any       <= 1'b0;
        end else if (pop) begin
            if (i_q_item.last) begin
                r_mode      <= MODE_SKIP;
                r_cur_start <= '0;
                r_lne       <= '0;
                r_ch_start  <= '0;
                r_ch_end    <= '0;
                r_match     <= 1'b0;
                r_any       <= 1'b0;
            end else begin
                r_mode      <= n_mode;
                r_cur_start <= n_cur_start;
                r_lne       <= n_lne;
                r_ch_start  <= n_ch_start;
                r_ch_end    <= n_ch_end;
                r_match     <= n_match;
                r_any       <= n_any;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop && i_q_item.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // With no sentence at all the whole text length is reported.
    always_ff @(posedge i_clk) begin
        if (pop && i_q_item.last) begin
            r_out.sentence_start <= n_any ? n_ch_start : '0;
            r_out.sentence_end   <= n_any ? n_ch_end : i_q_item.len;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

>>> rtl/sentence_boundary_locator.sv
// Top level of the sentence boundary locator: configuration registers and the front/back pipeline.
//
// The block scans text at one byte per clock cycle while the queue is not full and, on the item
// marked last, delivers one item with the start and exclusive end offset of the chosen sentence.
// The front end classifies each byte combinationally, including the case-insensitive abbreviation
// compare over the current word, and feeds a four-entry queue; the back end runs the sentence
// scanner and the target selection, also one item per cycle unless a last item waits on a
// stalled result, and holds the result in an output register, loaded when it takes the last item.
// A stall on the result side only holds up the next text's last item; its other bytes keep flowing
// until the queue fills. Configuration should be written only while no text is in flight.
module sentence_boundary_locator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sbl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sbl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  sbl_pkg::t_in                       i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output sbl_pkg::t_out                      o_out_item
);
    import sbl_pkg::*;

    logic [POS_W-1:0] r_target_index;
    logic             r_select_first;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_cls q_in;
    t_cls q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_index <= '0;
            r_select_first <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET_INDEX: r_target_index <= i_cfg_data[POS_W-1:0];
                CFG_SELECT_FIRST: r_select_first <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    sbl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_item   (q_in)
    );

    sbl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    sbl_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_item       (q_out),
        .o_q_pop        (q_pop),
        .i_target_index (r_target_index),
        .i_select_first (r_select_first),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_item     (o_out_item)
    );

endmodule
